FILE: src/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types, codes and helpers for the tree collective controller.
// ----------------------------------------------------------------------------
package tcc_pkg;

  // Field widths fixed by the item formats.
  localparam int unsigned SEQ_W = 32;
  localparam int unsigned CNT_W = 4;

  // Phase codes.
  localparam logic [1:0] PH_SYNC    = 2'd0;
  localparam logic [1:0] PH_COLLECT = 2'd1;
  localparam logic [1:0] PH_UPFWD   = 2'd2;
  localparam logic [1:0] PH_DOWNFWD = 2'd3;

  // Send status codes.
  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_ACTIVE = 2'd1;
  localparam logic [1:0] ST_FAILED = 2'd2;

  // Request type codes.
  localparam logic [2:0] REQ_LOCAL   = 3'd0;
  localparam logic [2:0] REQ_CHILD   = 3'd1;
  localparam logic [2:0] REQ_PARENT  = 3'd2;
  localparam logic [2:0] REQ_UP_DONE = 3'd3;
  localparam logic [2:0] REQ_DN_DONE = 3'd4;
  localparam logic [2:0] REQ_RELEASE = 3'd5;

  // Configuration register indexes.
  localparam logic [1:0] CFG_CHILD_COUNT = 2'd0;
  localparam logic [1:0] CFG_IS_ROOT     = 2'd1;

  // Saturation value of the completion counters.
  localparam logic [CNT_W-1:0] CNT_MAX = 4'd15;

  // Input event item.
  typedef struct packed {
    logic [2:0]       req_type;
    logic [2:0]       child_index;
    logic             from_known_peer;
    logic [SEQ_W-1:0] seq_tag;
    logic             send_ok;
    logic             has_callback;
  } req_item_t;

  // Result item.
  typedef struct packed {
    logic             accepted;
    logic [1:0]       phase;
    logic             start_up_send;
    logic             start_down_send;
    logic             deliver_local;
    logic             deliver_error;
    logic             terminate;
    logic             round_done;
    logic [SEQ_W-1:0] current_seq;
  } rsp_item_t;

  // Configuration write item.
  typedef struct packed {
    logic [1:0]       index;
    logic [CNT_W-1:0] data;
  } cfg_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic apply;
    logic step;
    logic publish;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic run_progress;
    logic step_stop;
  } dp_status_t;

  // Saturating increment of a completion counter.
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? CNT_MAX : v + 4'd1;
  endfunction

endpackage

FILE: src/tcc_stream_if.sv
// ----------------------------------------------------------------------------
// tcc_stream_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface tcc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/tcc_datapath.sv
// ----------------------------------------------------------------------------
// tcc_datapath
// Collective state registers, event handling and one progress transition
// per step command, plus the result register.
// ----------------------------------------------------------------------------
module tcc_datapath #(
  parameter int MAX_CHILDREN = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tcc_pkg::ctrl_cmd_t   cmd,
  output tcc_pkg::dp_status_t  stat,
  input  tcc_pkg::req_item_t   req_item,
  input  logic                 cfg_we,
  input  tcc_pkg::cfg_item_t   cfg_item,
  output tcc_pkg::rsp_item_t   rsp_item
);

  localparam logic [4:0] MAX_C = 5'(MAX_CHILDREN);

  // Configuration registers.
  logic [3:0] child_count;
  logic       is_root;

  // Collective state.
  logic [1:0]              phase_reg;
  logic [31:0]             round_seq;
  logic                    local_contributed;
  logic [MAX_CHILDREN-1:0] child_mask;
  logic [3:0]              child_seen_count;
  logic [1:0]              up_status;
  logic [1:0]              down_status;
  logic                    parent_arrived;
  logic [3:0]              down_wait_count;
  logic [3:0]              down_done_count;
  logic                    callback_pending;

  // Next values.
  logic [1:0]              phase_reg_next;
  logic [31:0]             round_seq_next;
  logic                    local_contributed_next;
  logic [MAX_CHILDREN-1:0] child_mask_next;
  logic [3:0]              child_seen_count_next;
  logic [1:0]              up_status_next;
  logic [1:0]              down_status_next;
  logic                    parent_arrived_next;
  logic [3:0]              down_wait_count_next;
  logic [3:0]              down_done_count_next;
  logic                    callback_pending_next;

  // Latched event and per-event result flags.
  tcc_pkg::req_item_t ev;
  logic accepted, flag_up, flag_down, flag_loc, flag_err, flag_term, flag_done;
  logic set_acc, set_up, set_down, set_loc, set_err, set_term, set_done;
  logic do_reset_tree;
  logic [1:0] down_eff;

  // Sequence comparisons share one subtractor.
  logic [31:0] seq_diff;
  logic        seq_eq, seq_plus, seq_minus;
  logic [MAX_CHILDREN-1:0] child_onehot;
  logic        child_known, child_seen;
  tcc_pkg::rsp_item_t rsp_q;

  assign seq_diff  = ev.seq_tag - round_seq;
  assign seq_eq    = (seq_diff == 32'd0);
  assign seq_plus  = (seq_diff == 32'd1);
  assign seq_minus = (seq_diff == 32'hFFFF_FFFF);

  // Decode the sending child.
  always_comb begin
    for (int i = 0; i < MAX_CHILDREN; i++) begin
      child_onehot[i] = ({2'b00, ev.child_index} == 5'(i));
    end
  end

  assign child_known = ev.from_known_peer && ({1'b0, ev.child_index} < child_count);
  assign child_seen  = |(child_mask & child_onehot);

  // Event handling and progress transitions.
  always_comb begin
    phase_reg_next         = phase_reg;
    round_seq_next         = round_seq;
    local_contributed_next = local_contributed;
    child_mask_next        = child_mask;
    child_seen_count_next  = child_seen_count;
    up_status_next         = up_status;
    down_status_next       = down_status;
    parent_arrived_next    = parent_arrived;
    down_wait_count_next   = down_wait_count;
    down_done_count_next   = down_done_count;
    callback_pending_next  = callback_pending;
    set_acc  = 1'b0;
    set_up   = 1'b0;
    set_down = 1'b0;
    set_loc  = 1'b0;
    set_err  = 1'b0;
    set_term = 1'b0;
    set_done = 1'b0;
    do_reset_tree     = 1'b0;
    stat.run_progress = 1'b0;
    stat.step_stop    = 1'b0;
    down_eff = (down_wait_count == down_done_count) ? tcc_pkg::ST_DONE : down_status;

    if (cmd.apply) begin
      case (ev.req_type)
        tcc_pkg::REQ_LOCAL: begin
          if (!(phase_reg == tcc_pkg::PH_UPFWD || local_contributed)) begin
            local_contributed_next = 1'b1;
            callback_pending_next  = ev.has_callback;
            set_acc                = 1'b1;
            stat.run_progress      = 1'b1;
          end
        end
        tcc_pkg::REQ_CHILD: begin
          if (phase_reg == tcc_pkg::PH_UPFWD ||
              (phase_reg == tcc_pkg::PH_DOWNFWD && !seq_plus) ||
              (phase_reg != tcc_pkg::PH_DOWNFWD && !seq_eq)) begin
            do_reset_tree = 1'b1;
            set_term      = 1'b1;
          end else if (child_known) begin
            if (!child_seen) begin
              child_mask_next       = child_mask | child_onehot;
              child_seen_count_next = tcc_pkg::sat_inc(child_seen_count);
            end
            set_acc           = 1'b1;
            stat.run_progress = 1'b1;
          end
        end
        tcc_pkg::REQ_PARENT: begin
          if (!ev.from_known_peer || is_root) begin
            set_acc           = 1'b1;
            stat.run_progress = 1'b1;
          end else if ((phase_reg == tcc_pkg::PH_SYNC || phase_reg == tcc_pkg::PH_COLLECT)
                       && !seq_minus) begin
            do_reset_tree = 1'b1;
            set_term      = 1'b1;
          end else if (phase_reg == tcc_pkg::PH_DOWNFWD && !seq_eq) begin
            do_reset_tree = 1'b1;
            set_term      = 1'b1;
          end else begin
            if (phase_reg == tcc_pkg::PH_UPFWD) begin
              parent_arrived_next = 1'b1;
            end
            set_acc           = 1'b1;
            stat.run_progress = 1'b1;
          end
        end
        tcc_pkg::REQ_UP_DONE: begin
          if (!ev.send_ok) begin
            up_status_next = tcc_pkg::ST_FAILED;
            set_acc        = 1'b1;
          end else begin
            if (seq_eq) begin
              up_status_next = tcc_pkg::ST_DONE;
              set_acc        = 1'b1;
            end
            stat.run_progress = 1'b1;
          end
        end
        tcc_pkg::REQ_DN_DONE: begin
          if (!ev.send_ok) begin
            down_status_next = tcc_pkg::ST_FAILED;
            set_acc          = 1'b1;
          end else begin
            if (seq_eq) begin
              down_done_count_next = tcc_pkg::sat_inc(down_done_count);
              set_acc              = 1'b1;
            end
            stat.run_progress = 1'b1;
          end
        end
        tcc_pkg::REQ_RELEASE: begin
          if (seq_eq && phase_reg == tcc_pkg::PH_DOWNFWD) begin
            down_done_count_next = tcc_pkg::sat_inc(down_done_count);
            set_acc              = 1'b1;
            stat.run_progress    = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end else if (cmd.step) begin
      case (phase_reg)
        tcc_pkg::PH_SYNC: begin
          if (!(local_contributed || child_seen_count != 4'd0)) begin
            stat.step_stop = 1'b1;
          end else begin
            phase_reg_next = tcc_pkg::PH_COLLECT;
          end
        end
        tcc_pkg::PH_COLLECT: begin
          if (!local_contributed || child_seen_count != child_count) begin
            stat.step_stop = 1'b1;
          end else begin
            phase_reg_next = tcc_pkg::PH_UPFWD;
            if (!is_root) begin
              up_status_next = tcc_pkg::ST_ACTIVE;
              set_up         = 1'b1;
            end else begin
              up_status_next      = tcc_pkg::ST_DONE;
              parent_arrived_next = 1'b1;
            end
          end
        end
        tcc_pkg::PH_UPFWD: begin
          if (up_status == tcc_pkg::ST_FAILED) begin
            set_err               = callback_pending;
            callback_pending_next = 1'b0;
            do_reset_tree         = 1'b1;
            stat.step_stop        = 1'b1;
          end else if (up_status == tcc_pkg::ST_ACTIVE || !parent_arrived) begin
            stat.step_stop = 1'b1;
          end else begin
            // Upward half is finished: clear it and start the broadcast.
            child_seen_count_next  = 4'd0;
            local_contributed_next = 1'b0;
            child_mask_next        = '0;
            up_status_next         = tcc_pkg::ST_DONE;
            phase_reg_next         = tcc_pkg::PH_DOWNFWD;
            down_status_next       = tcc_pkg::ST_ACTIVE;
            down_wait_count_next   = child_count;
            set_down               = (child_count != 4'd0);
            if (callback_pending) begin
              down_wait_count_next  = tcc_pkg::sat_inc(child_count);
              set_loc               = 1'b1;
              callback_pending_next = 1'b0;
            end
          end
        end
        default: begin
          down_status_next = down_eff;
          if (down_eff == tcc_pkg::ST_ACTIVE) begin
            stat.step_stop = 1'b1;
          end else if (down_eff == tcc_pkg::ST_FAILED) begin
            set_err               = callback_pending;
            callback_pending_next = 1'b0;
            do_reset_tree         = 1'b1;
            stat.step_stop        = 1'b1;
          end else begin
            do_reset_tree = 1'b1;
            set_done      = 1'b1;
          end
        end
      endcase
    end

    // Tree reset overrides the fields it touches.
    if (do_reset_tree) begin
      case (phase_reg) inside
        tcc_pkg::PH_COLLECT, tcc_pkg::PH_UPFWD: begin
          round_seq_next         = round_seq + 32'd1;
          phase_reg_next         = tcc_pkg::PH_SYNC;
          child_seen_count_next  = 4'd0;
          local_contributed_next = 1'b0;
          child_mask_next        = '0;
          up_status_next         = tcc_pkg::ST_DONE;
          down_done_count_next   = 4'd0;
          down_wait_count_next   = 4'd0;
          down_status_next       = tcc_pkg::ST_DONE;
          parent_arrived_next    = 1'b0;
          callback_pending_next  = 1'b0;
        end
        tcc_pkg::PH_DOWNFWD: begin
          round_seq_next       = round_seq + 32'd1;
          down_done_count_next = 4'd0;
          down_wait_count_next = 4'd0;
          down_status_next     = tcc_pkg::ST_DONE;
          parent_arrived_next  = 1'b0;
          phase_reg_next       = (local_contributed || child_seen_count != 4'd0) ?
                                 tcc_pkg::PH_COLLECT : tcc_pkg::PH_SYNC;
        end
        default: begin
        end
      endcase
    end
  end

  // Configuration and collective state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      child_count       <= 4'd0;
      is_root           <= 1'b1;
      phase_reg         <= tcc_pkg::PH_SYNC;
      round_seq         <= 32'd0;
      local_contributed <= 1'b0;
      child_mask        <= '0;
      child_seen_count  <= 4'd0;
      up_status         <= tcc_pkg::ST_DONE;
      down_status       <= tcc_pkg::ST_DONE;
      parent_arrived    <= 1'b0;
      down_wait_count   <= 4'd0;
      down_done_count   <= 4'd0;
      callback_pending  <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_item.index == tcc_pkg::CFG_CHILD_COUNT) begin
          child_count <= ({1'b0, cfg_item.data} > MAX_C) ? MAX_C[3:0] : cfg_item.data;
        end else if (cfg_item.index == tcc_pkg::CFG_IS_ROOT) begin
          is_root <= cfg_item.data[0];
        end
      end
      phase_reg         <= phase_reg_next;
      round_seq         <= round_seq_next;
      local_contributed <= local_contributed_next;
      child_mask        <= child_mask_next;
      child_seen_count  <= child_seen_count_next;
      up_status         <= up_status_next;
      down_status       <= down_status_next;
      parent_arrived    <= parent_arrived_next;
      down_wait_count   <= down_wait_count_next;
      down_done_count   <= down_done_count_next;
      callback_pending  <= callback_pending_next;
    end
  end

  // Per-event flags collect strobes over all transitions of one event.
  always_ff @(posedge clk) begin
    if (rst) begin
      accepted  <= 1'b0;
      flag_up   <= 1'b0;
      flag_down <= 1'b0;
      flag_loc  <= 1'b0;
      flag_err  <= 1'b0;
      flag_term <= 1'b0;
      flag_done <= 1'b0;
    end else if (cmd.load) begin
      accepted  <= 1'b0;
      flag_up   <= 1'b0;
      flag_down <= 1'b0;
      flag_loc  <= 1'b0;
      flag_err  <= 1'b0;
      flag_term <= 1'b0;
      flag_done <= 1'b0;
    end else begin
      accepted  <= accepted | set_acc;
      flag_up   <= flag_up | set_up;
      flag_down <= flag_down | set_down;
      flag_loc  <= flag_loc | set_loc;
      flag_err  <= flag_err | set_err;
      flag_term <= flag_term | set_term;
      flag_done <= flag_done | set_done;
    end
  end

  // Event and result payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ev <= req_item;
    end
    if (cmd.publish) begin
      rsp_q.accepted        <= accepted;
      rsp_q.phase           <= phase_reg;
      rsp_q.start_up_send   <= flag_up;
      rsp_q.start_down_send <= flag_down;
      rsp_q.deliver_local   <= flag_loc;
      rsp_q.deliver_error   <= flag_err;
      rsp_q.terminate       <= flag_term;
      rsp_q.round_done      <= flag_done;
      rsp_q.current_seq     <= round_seq;
    end
  end

  assign rsp_item = rsp_q;

endmodule

FILE: src/tcc_ctrl.sv
// ----------------------------------------------------------------------------
// tcc_ctrl
// Sequencer for one event: load, apply, progress steps, then publish the
// result into the output register.
// ----------------------------------------------------------------------------
module tcc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  tcc_pkg::dp_status_t stat,
  output tcc_pkg::ctrl_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_APPLY   = 2'd1;
  localparam logic [1:0] S_STEP    = 2'd2;
  localparam logic [1:0] S_PUBLISH = 2'd3;

  logic [1:0] state, state_next;
  logic [4:0] guard, guard_next;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // Next state and commands.
  always_comb begin
    state_next  = state;
    guard_next  = guard;
    cmd.load    = 1'b0;
    cmd.apply   = 1'b0;
    cmd.step    = 1'b0;
    cmd.publish = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply  = 1'b1;
        guard_next = 5'd0;
        state_next = stat.run_progress ? S_STEP : S_PUBLISH;
      end
      S_STEP: begin
        // At most 32 phase transitions per event.
        cmd.step   = 1'b1;
        guard_next = guard + 5'd1;
        if (stat.step_stop || guard == 5'd31) begin
          state_next = S_PUBLISH;
        end
      end
      S_PUBLISH: begin
        if (out_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State, step guard and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      guard     <= 5'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      guard <= guard_next;
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_accept_applies: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid) |=> (state == S_APPLY))
    else $error("accepted event was not applied");
  a_guard_limit: assert property (@(posedge clk) disable iff (rst)
    (state == S_STEP && guard == 5'd31) |=> (state == S_PUBLISH))
    else $error("progress ran past its step limit");
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.apply, cmd.step, cmd.publish}))
    else $error("more than one datapath command");
  a_publish_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |=> out_valid)
    else $error("published result not presented");
`endif

endmodule

FILE: src/tree_collective_controller.sv
// ----------------------------------------------------------------------------
// tree_collective_controller
// Control engine for one node of a tree-based collective round.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one event per transfer (local, child or parent contribution,
//   send completions, local release). rsp returns exactly one result per
//   event with the action strobes, phase and sequence number. cfg writes
//   child_count (index 0) and is_root (index 1); it is always ready. The user
//   must write it only while no event is in flight; the block does not check.
//   Sequence: an event is applied in the cycle after its transfer. Each
//   progress step then makes at most one phase transition, and a chain
//   ends with the step that stops or at the step limit. The publish state
//   then loads the output register, once rsp can take it. An event that
//   does not retry progress runs no steps; one that does runs 1 to 32.
//   Events are handled one at a time; req is ready again once the result is
//   in the output register.
//   When rsp stalls with a result held, the next event waits at publish.
//   Reset (rst, synchronous) clears the phase, sequence, counters and the
//   configuration (child_count 0, is_root 1) and drops any pending result.
// ----------------------------------------------------------------------------
module tree_collective_controller #(
  parameter int MAX_CHILDREN = 8
) (
  input logic          clk,
  input logic          rst,
  tcc_stream_if.sink   req,
  tcc_stream_if.source rsp,
  tcc_stream_if.sink   cfg
);

  tcc_pkg::ctrl_cmd_t  cmd;
  tcc_pkg::dp_status_t stat;

  assign cfg.ready = 1'b1;

  // Event sequencer.
  tcc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // State registers and transition logic.
  tcc_datapath #(
    .MAX_CHILDREN (MAX_CHILDREN)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .req_item (req.payload),
    .cfg_we   (cfg.valid),
    .cfg_item (cfg.payload),
    .rsp_item (rsp.payload)
  );

endmodule

FILE: dv/tree_collective_controller_test.sv
// ----------------------------------------------------------------------------
// tree_collective_controller_test
// Self-checking bench for the tree collective controller. A scoreboard keeps
// its own copy of the node state, predicts one result per accepted event and
// checks the results in order. A directed prologue is followed by random
// rounds under several tree settings, with bursty events and a stalling
// result receiver.
// ----------------------------------------------------------------------------
module tree_collective_controller_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_KIDS = 8;
  localparam int LIMIT_CYCLES = 300000;
  localparam int EVENTS_PER_SETTING = 105;
  localparam int DRAIN_CYCLES = 40;
  localparam int NUM_SETTINGS = 6;

  // Request codes that the block must ignore.
  localparam logic [2:0] REQ_UNUSED_LO = 3'd6;
  localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

  // Scoreboard: tracks the node state, predicts each result and checks it.
  class collective_scoreboard;
    logic [3:0]  child_count;
    logic        is_root;
    logic [1:0]  phase;
    logic [31:0] round_seq;
    logic        local_done;
    logic [7:0]  child_mask;
    logic [3:0]  seen_count;
    logic [1:0]  up_status;
    logic [1:0]  down_status;
    logic        parent_in;
    logic [3:0]  down_wait;
    logic [3:0]  down_count;
    logic        cb_pending;
    logic        s_up, s_down, s_local, s_err, s_term, s_done;
    tcc_pkg::rsp_item_t pending_results[$];
    int          errors;
    int          checked;

    function new();
      restart();
      errors = 0;
      checked = 0;
    endfunction

    function void restart();
      child_count = 4'd0;
      is_root = 1'b1;
      phase = tcc_pkg::PH_SYNC;
      round_seq = '0;
      local_done = 1'b0;
      child_mask = '0;
      seen_count = '0;
      up_status = tcc_pkg::ST_DONE;
      down_status = tcc_pkg::ST_DONE;
      parent_in = 1'b0;
      down_wait = '0;
      down_count = '0;
      cb_pending = 1'b0;
      pending_results.delete();
    endfunction

    function void write_reg(tcc_pkg::cfg_item_t c);
      if (c.index == tcc_pkg::CFG_CHILD_COUNT) begin
        child_count = (c.data > MAX_KIDS) ? 4'(MAX_KIDS) : c.data;
      end else if (c.index == tcc_pkg::CFG_IS_ROOT) begin
        is_root = c.data[0];
      end
    endfunction

    function logic [3:0] bump(logic [3:0] v);
      return (v == tcc_pkg::CNT_MAX) ? tcc_pkg::CNT_MAX : v + 4'd1;
    endfunction

    function void clear_up();
      seen_count = '0;
      local_done = 1'b0;
      child_mask = '0;
      up_status = tcc_pkg::ST_DONE;
    endfunction

    function void clear_down();
      down_count = '0;
      down_wait = '0;
      down_status = tcc_pkg::ST_DONE;
      parent_in = 1'b0;
    endfunction

    // Abandon the round: the sequence moves on and the collected state is
    // dropped, except that contributions already made for the next round
    // survive an abort from down-forward.
    function void unwind();
      if (phase == tcc_pkg::PH_COLLECT || phase == tcc_pkg::PH_UPFWD) begin
        round_seq++;
        phase = tcc_pkg::PH_SYNC;
        clear_up();
        clear_down();
        cb_pending = 1'b0;
      end else if (phase == tcc_pkg::PH_DOWNFWD) begin
        round_seq++;
        clear_down();
        phase = (local_done || seen_count != 0) ? tcc_pkg::PH_COLLECT : tcc_pkg::PH_SYNC;
      end
    endfunction

    // Take as many phase transitions as the state allows.
    function void settle();
      for (int g = 0; g < 32; g++) begin
        if (phase == tcc_pkg::PH_SYNC) begin
          if (!(local_done || seen_count != 0)) return;
          phase = tcc_pkg::PH_COLLECT;
        end else if (phase == tcc_pkg::PH_COLLECT) begin
          if (!local_done || seen_count != child_count) return;
          phase = tcc_pkg::PH_UPFWD;
          if (!is_root) begin
            up_status = tcc_pkg::ST_ACTIVE;
            s_up = 1'b1;
          end else begin
            up_status = tcc_pkg::ST_DONE;
            parent_in = 1'b1;
          end
        end else if (phase == tcc_pkg::PH_UPFWD) begin
          if (up_status == tcc_pkg::ST_FAILED) begin
            if (cb_pending) s_err = 1'b1;
            cb_pending = 1'b0;
            unwind();
            return;
          end
          if (up_status == tcc_pkg::ST_ACTIVE || !parent_in) return;
          clear_up();
          phase = tcc_pkg::PH_DOWNFWD;
          down_status = tcc_pkg::ST_ACTIVE;
          down_wait = child_count;
          if (child_count != 0) s_down = 1'b1;
          if (cb_pending) begin
            down_wait = bump(down_wait);
            s_local = 1'b1;
            cb_pending = 1'b0;
          end
        end else begin
          if (down_wait == down_count) down_status = tcc_pkg::ST_DONE;
          if (down_status == tcc_pkg::ST_ACTIVE) return;
          if (down_status == tcc_pkg::ST_FAILED) begin
            if (cb_pending) s_err = 1'b1;
            cb_pending = 1'b0;
            unwind();
            return;
          end
          unwind();
          s_done = 1'b1;
        end
      end
    endfunction

    function logic raise_fault();
      unwind();
      s_term = 1'b1;
      return 1'b0;
    endfunction

    // Apply one event to the state; returns whether it is accepted.
    function logic handle(tcc_pkg::req_item_t e);
      case (e.req_type)
        tcc_pkg::REQ_LOCAL: begin
          if (phase == tcc_pkg::PH_UPFWD || local_done) return 1'b0;
          local_done = 1'b1;
          cb_pending = e.has_callback;
          settle();
          return 1'b1;
        end
        tcc_pkg::REQ_CHILD: begin
          if (phase == tcc_pkg::PH_UPFWD) return raise_fault();
          if (phase == tcc_pkg::PH_DOWNFWD) begin
            if (e.seq_tag != round_seq + 32'd1) return raise_fault();
          end else if (e.seq_tag != round_seq) begin
            return raise_fault();
          end
          if (!e.from_known_peer || {1'b0, e.child_index} >= child_count) return 1'b0;
          if (!child_mask[e.child_index]) begin
            child_mask[e.child_index] = 1'b1;
            seen_count = bump(seen_count);
          end
          settle();
          return 1'b1;
        end
        tcc_pkg::REQ_PARENT: begin
          if (!e.from_known_peer || is_root) begin
            settle();
            return 1'b1;
          end
          if (phase == tcc_pkg::PH_SYNC || phase == tcc_pkg::PH_COLLECT) begin
            if (e.seq_tag != round_seq - 32'd1) return raise_fault();
          end else if (phase == tcc_pkg::PH_DOWNFWD) begin
            if (e.seq_tag != round_seq) return raise_fault();
          end else begin
            parent_in = 1'b1;
          end
          settle();
          return 1'b1;
        end
        tcc_pkg::REQ_UP_DONE: begin
          if (!e.send_ok) begin
            up_status = tcc_pkg::ST_FAILED;
            return 1'b1;
          end
          if (e.seq_tag != round_seq) begin
            settle();
            return 1'b0;
          end
          up_status = tcc_pkg::ST_DONE;
          settle();
          return 1'b1;
        end
        tcc_pkg::REQ_DN_DONE: begin
          if (!e.send_ok) begin
            down_status = tcc_pkg::ST_FAILED;
            return 1'b1;
          end
          if (e.seq_tag != round_seq) begin
            settle();
            return 1'b0;
          end
          down_count = bump(down_count);
          settle();
          return 1'b1;
        end
        tcc_pkg::REQ_RELEASE: begin
          if (e.seq_tag != round_seq || phase != tcc_pkg::PH_DOWNFWD) return 1'b0;
          down_count = bump(down_count);
          settle();
          return 1'b1;
        end
        default: return 1'b0;
      endcase
    endfunction

    // Record an accepted event and queue the result it must produce.
    function void note_event(tcc_pkg::req_item_t e);
      tcc_pkg::rsp_item_t r;
      {s_up, s_down, s_local, s_err, s_term, s_done} = '0;
      r.accepted = handle(e);
      r.phase = phase;
      r.start_up_send = s_up;
      r.start_down_send = s_down;
      r.deliver_local = s_local;
      r.deliver_error = s_err;
      r.terminate = s_term;
      r.round_done = s_done;
      r.current_seq = round_seq;
      pending_results.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
        report($sformatf("result %0d %s: got %0h, want %0h", checked, name, got, want));
      end
    endtask

    // Check one transferred result against the oldest prediction.
    task check_result(tcc_pkg::rsp_item_t got);
      tcc_pkg::rsp_item_t want;
      if (pending_results.size() == 0) begin
        report("result transferred with no event outstanding");
        return;
      end
      want = pending_results.pop_front();
      compare_field("accepted", 32'(got.accepted), 32'(want.accepted));
      compare_field("phase", 32'(got.phase), 32'(want.phase));
      compare_field("start_up_send", 32'(got.start_up_send), 32'(want.start_up_send));
      compare_field("start_down_send", 32'(got.start_down_send),
                    32'(want.start_down_send));
      compare_field("deliver_local", 32'(got.deliver_local), 32'(want.deliver_local));
      compare_field("deliver_error", 32'(got.deliver_error), 32'(want.deliver_error));
      compare_field("terminate", 32'(got.terminate), 32'(want.terminate));
      compare_field("round_done", 32'(got.round_done), 32'(want.round_done));
      compare_field("current_seq", got.current_seq, want.current_seq);
      checked++;
    endtask
  endclass

  logic clk;
  logic rst;

  tcc_stream_if #(.payload_t(tcc_pkg::req_item_t)) req_ch ();
  tcc_stream_if #(.payload_t(tcc_pkg::rsp_item_t)) rsp_ch ();
  tcc_stream_if #(.payload_t(tcc_pkg::cfg_item_t)) cfg_ch ();

  tree_collective_controller #(.MAX_CHILDREN(MAX_KIDS)) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  collective_scoreboard sb = new();
  int cycles = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int storm_left = 0;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("** tree_collective_controller: FAILED **");
      $finish;
    end
  end

  // Observe every transfer on the three channels.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) sb.write_reg(cfg_ch.payload);
      if (req_ch.valid && req_ch.ready) sb.note_event(req_ch.payload);
      if (rsp_ch.valid && rsp_ch.ready) sb.check_result(rsp_ch.payload);
    end
  end

  // The result receiver switches between stall patterns at random.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 96);
    end
    stall_left--;
    case (stall_mode)
      0: rsp_ch.ready <= 1'b1;
      1: rsp_ch.ready <= 1'($urandom_range(0, 1));
      2: rsp_ch.ready <= ($urandom_range(0, 4) == 0);
      default: rsp_ch.ready <= (rsp_ch.ready !== 1'b1);
    endcase
  end

  function automatic tcc_pkg::req_item_t make_event(logic [2:0] kind, logic [2:0] idx,
                                                    logic known, logic [31:0] tag,
                                                    logic ok, logic cb);
    tcc_pkg::req_item_t it;
    it.req_type = kind;
    it.child_index = idx;
    it.from_known_peer = known;
    it.seq_tag = tag;
    it.send_ok = ok;
    it.has_callback = cb;
    return it;
  endfunction

  function automatic logic coin();
    return 1'($urandom_range(0, 1));
  endfunction

  // Arbitrary event with tags near the current sequence, random, zero or all ones.
  function automatic tcc_pkg::req_item_t noise_event();
    logic [31:0] tag;
    case ($urandom_range(0, 5))
      0: tag = sb.round_seq;
      1: tag = sb.round_seq + 32'd1;
      2: tag = sb.round_seq - 32'd1;
      3: tag = $urandom;
      4: tag = '0;
      default: tag = '1;
    endcase
    return make_event(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), coin(), tag,
                      coin(), coin());
  endfunction

  // Event that moves the current round forward, chosen from the tracked state.
  function automatic tcc_pkg::req_item_t round_event();
    tcc_pkg::req_item_t it;
    int missing[$];
    logic [31:0] seq;
    seq = sb.round_seq;
    // An unknown parent only retries progress; used where nothing else fits.
    it = make_event(tcc_pkg::REQ_PARENT, 3'($urandom_range(0, 7)), 1'b0, $urandom, coin(),
                    coin());
    if (sb.phase == tcc_pkg::PH_SYNC || sb.phase == tcc_pkg::PH_COLLECT) begin
      for (int i = 0; i < sb.child_count; i++) begin
        if (!sb.child_mask[i]) missing.push_back(i);
      end
      if (!sb.is_root && $urandom_range(0, 7) == 0) begin
        it = make_event(tcc_pkg::REQ_PARENT, 3'($urandom_range(0, 7)), 1'b1, seq - 32'd1,
                        coin(), coin());
      end else if (!sb.local_done && (missing.size() == 0 || $urandom_range(0, 3) == 0)) begin
        it = make_event(tcc_pkg::REQ_LOCAL, 3'($urandom_range(0, 7)), coin(), $urandom,
                        coin(), coin());
      end else if (missing.size() != 0) begin
        it = make_event(tcc_pkg::REQ_CHILD, 3'(missing[$urandom_range(0, missing.size() - 1)]),
                        1'b1, seq, coin(), coin());
      end else begin
        // Wedged after the child count shrank: a bad sequence clears the tree.
        it = make_event(tcc_pkg::REQ_CHILD, '0, 1'b1, seq + 32'd7, 1'b1, 1'b0);
      end
    end else if (sb.phase == tcc_pkg::PH_UPFWD) begin
      if (sb.up_status == tcc_pkg::ST_ACTIVE && (sb.parent_in || coin())) begin
        it = make_event(tcc_pkg::REQ_UP_DONE, 3'($urandom_range(0, 7)), coin(), seq,
                        $urandom_range(0, 11) != 0, coin());
      end else if (sb.up_status != tcc_pkg::ST_FAILED && !sb.parent_in) begin
        it = make_event(tcc_pkg::REQ_PARENT, 3'($urandom_range(0, 7)), 1'b1, $urandom,
                        coin(), coin());
      end
    end else if (sb.down_status != tcc_pkg::ST_FAILED) begin
      if (sb.down_count > sb.down_wait) begin
        // Too many completions were counted: fail the broadcast to unwind.
        it = make_event(tcc_pkg::REQ_DN_DONE, '0, 1'b1, seq, 1'b0, 1'b0);
      end else if (sb.child_count != 0 && $urandom_range(0, 7) == 0) begin
        it = make_event(tcc_pkg::REQ_CHILD, 3'($urandom_range(0, sb.child_count - 1)), 1'b1,
                        seq + 32'd1, coin(), coin());
      end else if ($urandom_range(0, 2) == 0) begin
        it = make_event(tcc_pkg::REQ_RELEASE, 3'($urandom_range(0, 7)), coin(), seq, coin(),
                        coin());
      end else begin
        it = make_event(tcc_pkg::REQ_DN_DONE, 3'($urandom_range(0, 7)), coin(), seq,
                        $urandom_range(0, 11) != 0, coin());
      end
    end
    return it;
  endfunction

  // Mostly well-formed rounds, with noise and occasional completion storms
  // that drive the completion counter into saturation.
  function automatic tcc_pkg::req_item_t next_event();
    if (storm_left == 0 && $urandom_range(0, 199) == 0) storm_left = 16;
    if (storm_left != 0) begin
      storm_left--;
      return make_event(tcc_pkg::REQ_DN_DONE, '0, 1'b1, sb.round_seq, 1'b1, 1'b0);
    end
    if ($urandom_range(0, 4) != 0) return round_event();
    return noise_event();
  endfunction

  // Present one event and hold it until its transfer.
  task automatic offer(tcc_pkg::req_item_t it);
    req_ch.valid <= 1'b1;
    req_ch.payload <= it;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic post(logic [2:0] kind, logic [2:0] idx, logic known, logic [31:0] tag,
                      logic ok, logic cb);
    @(negedge clk);
    offer(make_event(kind, idx, known, tag, ok, cb));
  endtask

  // Stop sending and wait until every predicted result has been transferred.
  task automatic drain();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_config(logic [1:0] idx, logic [3:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.payload <= '{index: idx, data: data};
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Main sequence: reset, directed events, then random rounds per setting.
  initial begin
    logic [3:0] count_data [NUM_SETTINGS];
    logic [3:0] root_data [NUM_SETTINGS];
    tcc_pkg::req_item_t it;
    int burst_left;
    int gap;
    int sent;

    count_data = '{4'd8, 4'd0, 4'd15, 4'd3, 4'd1, 4'd11};
    root_data = '{4'd0, 4'd1, 4'd14, 4'd0, 4'd15, 4'd2};
    burst_left = 0;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.payload = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.payload = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset configuration: a root with no children.
    post(REQ_UNUSED_LO, '0, 1'b1, '0, 1'b1, 1'b1);
    post(REQ_UNUSED_HI, '1, 1'b0, '1, 1'b0, 1'b0);
    post(tcc_pkg::REQ_RELEASE, '0, 1'b1, 32'd0, 1'b1, 1'b0);
    post(tcc_pkg::REQ_UP_DONE, '0, 1'b1, 32'd5, 1'b1, 1'b0);
    post(tcc_pkg::REQ_PARENT, '0, 1'b1, 32'd0, 1'b1, 1'b0);
    post(tcc_pkg::REQ_CHILD, '0, 1'b1, 32'd0, 1'b1, 1'b0);
    post(tcc_pkg::REQ_CHILD, '0, 1'b1, 32'd3, 1'b1, 1'b0);

    // Inner node with two children: rejects, an abort, a failed upward
    // send, then a complete round with local delivery.
    drain();
    write_config(tcc_pkg::CFG_CHILD_COUNT, 4'd2);
    write_config(tcc_pkg::CFG_IS_ROOT, 4'd0);
    post(tcc_pkg::REQ_PARENT, '0, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0);
    post(tcc_pkg::REQ_PARENT, '0, 1'b1, 32'd0, 1'b1, 1'b0);
    post(tcc_pkg::REQ_LOCAL, '0, 1'b0, 32'd0, 1'b0, 1'b1);
    post(tcc_pkg::REQ_LOCAL, '0, 1'b0, 32'd0, 1'b0, 1'b0);
    post(tcc_pkg::REQ_CHILD, 3'd0, 1'b1, 32'd0, 1'b1, 1'b0);
    post(tcc_pkg::REQ_CHILD, 3'd0, 1'b1, 32'd0, 1'b1, 1'b0);
    post(tcc_pkg::REQ_CHILD, 3'd5, 1'b1, 32'd0, 1'b1, 1'b0);
    post(tcc_pkg::REQ_CHILD, 3'd1, 1'b0, 32'd0, 1'b1, 1'b0);
    post(tcc_pkg::REQ_CHILD, 3'd1, 1'b1, 32'd0, 1'b1, 1'b0);
    post(tcc_pkg::REQ_LOCAL, '0, 1'b0, 32'd0, 1'b1, 1'b1);
    post(tcc_pkg::REQ_CHILD, 3'd1, 1'b1, 32'd0, 1'b1, 1'b0);
    post(tcc_pkg::REQ_LOCAL, '0, 1'b0, 32'd0, 1'b1, 1'b1);
    post(tcc_pkg::REQ_CHILD, 3'd0, 1'b1, 32'd1, 1'b1, 1'b0);
    post(tcc_pkg::REQ_CHILD, 3'd1, 1'b1, 32'd1, 1'b1, 1'b0);
    post(tcc_pkg::REQ_UP_DONE, '0, 1'b1, 32'd1, 1'b0, 1'b0);
    post(tcc_pkg::REQ_PARENT, '0, 1'b1, 32'h1234_5678, 1'b1, 1'b0);
    post(tcc_pkg::REQ_LOCAL, '0, 1'b0, 32'd0, 1'b1, 1'b1);
    post(tcc_pkg::REQ_CHILD, 3'd0, 1'b1, 32'd2, 1'b1, 1'b0);
    post(tcc_pkg::REQ_CHILD, 3'd1, 1'b1, 32'd2, 1'b1, 1'b0);
    post(tcc_pkg::REQ_UP_DONE, '0, 1'b1, 32'd9, 1'b1, 1'b0);
    post(tcc_pkg::REQ_UP_DONE, '0, 1'b1, 32'd2, 1'b1, 1'b0);
    post(tcc_pkg::REQ_PARENT, '0, 1'b1, 32'd0, 1'b1, 1'b0);
    post(tcc_pkg::REQ_RELEASE, '0, 1'b1, 32'd2, 1'b1, 1'b0);
    post(tcc_pkg::REQ_DN_DONE, '0, 1'b1, 32'd2, 1'b1, 1'b0);
    post(tcc_pkg::REQ_DN_DONE, '0, 1'b1, 32'd2, 1'b1, 1'b0);

    // Random rounds under each tree setting, sent in bursts with gaps.
    for (int s = 0; s < NUM_SETTINGS; s++) begin
      drain();
      write_config(tcc_pkg::CFG_CHILD_COUNT, count_data[s]);
      write_config(tcc_pkg::CFG_IS_ROOT, root_data[s]);
      sent = 0;
      while (sent < EVENTS_PER_SETTING) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          repeat (gap) begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
          end
        end
        @(negedge clk);
        it = next_event();
        offer(it);
        burst_left--;
        if (it.req_type <= tcc_pkg::REQ_RELEASE) sent++;
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("** tree_collective_controller: PASSED **");
    end else begin
      $display("** tree_collective_controller: FAILED **");
    end
    $finish;
  end

endmodule
